// File: rtl/blemd_pkg.sv
package blemd_pkg;

    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = $clog2(FifoDepth);
    localparam int FifoCntW  = $clog2(FifoDepth + 1);

    localparam int AddrW = 3;
    localparam int DataW = 32;

    typedef enum logic [0:0] {
        REG_ACCEPTED_HANDLE = 1'b0,
        REG_RECEIVE_ENABLE  = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_MESSAGE = 2'd0,
        KIND_SEG_END = 2'd1,
        KIND_ERROR   = 2'd2
    } item_kind_t;

    typedef enum logic [1:0] {
        ERR_BAD_HEADER = 2'd0,
        ERR_BAD_TS_LOW = 2'd1,
        ERR_TRUNC_TS   = 2'd2
    } error_code_t;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  message_byte;
        logic [12:0] stamp;
        logic        segment_first;
        logic [1:0]  error_code;
        logic        run_last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_t;

endpackage

// File: rtl/blemd_parser.sv
module blemd_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            packet_byte,
    input  logic                  end_of_packet,
    input  logic [15:0]           packet_handle,
    input  logic [15:0]           accepted_handle,
    input  logic                  receive_enable,
    output blemd_pkg::step_t      step
);
    import blemd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_TS_FIRST = 3'd1,
        PH_BAD_HDR  = 3'd2,
        PH_MESSAGE  = 3'd3,
        PH_DATA     = 3'd4,
        PH_DISCARD  = 3'd5
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [5:0]  stamp_high_reg;
    logic [5:0]  stamp_high_next;
    logic [6:0]  stamp_low_reg;
    logic [6:0]  stamp_low_next;
    logic [12:0] cur_stamp;
    logic        top;
    result_t     msg_item;
    result_t     end_item;
    result_t     err_item;

    assign cur_stamp = {stamp_high_reg, stamp_low_reg};
    assign top       = packet_byte[7];

    always_comb
    begin
        msg_item               = '0;
        msg_item.item_kind     = KIND_MESSAGE;
        msg_item.message_byte  = packet_byte;
        msg_item.stamp         = cur_stamp;
        end_item               = '0;
        end_item.item_kind     = KIND_SEG_END;
        end_item.stamp         = cur_stamp;
        err_item               = '0;
        err_item.item_kind     = KIND_ERROR;
    end

    always_comb
    begin
        step            = '0;
        phase_next      = phase_reg;
        stamp_high_next = stamp_high_reg;
        stamp_low_next  = stamp_low_reg;
        unique case (phase_reg)
            PH_HEADER:
            begin
                priority if (packet_handle != accepted_handle || !receive_enable)
                    phase_next = end_of_packet ? PH_HEADER : PH_DISCARD;
                else if (end_of_packet)
                    phase_next = PH_HEADER;
                else if (top)
                begin
                    stamp_high_next = packet_byte[5:0];
                    phase_next      = PH_TS_FIRST;
                end
                else
                    phase_next = PH_BAD_HDR;
            end
            PH_TS_FIRST:
            begin
                priority if (end_of_packet)
                    phase_next = PH_HEADER;
                else if (top)
                begin
                    stamp_low_next = packet_byte[6:0];
                    phase_next     = PH_MESSAGE;
                end
                else
                begin
                    step.count               = 2'd1;
                    step.first               = err_item;
                    step.first.error_code    = ERR_BAD_TS_LOW;
                    step.first.run_last      = 1'b1;
                    phase_next               = PH_DISCARD;
                end
            end
            PH_BAD_HDR:
            begin
                if (end_of_packet)
                    phase_next = PH_HEADER;
                else
                begin
                    step.count            = 2'd1;
                    step.first            = err_item;
                    step.first.error_code = ERR_BAD_HEADER;
                    step.first.run_last   = 1'b1;
                    phase_next            = PH_DISCARD;
                end
            end
            PH_MESSAGE:
            begin
                step.first               = msg_item;
                step.first.segment_first = 1'b1;
                if (end_of_packet)
                begin
                    step.count           = 2'd2;
                    step.second          = end_item;
                    step.second.run_last = 1'b1;
                    phase_next           = PH_HEADER;
                end
                else
                begin
                    step.count          = 2'd1;
                    step.first.run_last = 1'b1;
                    phase_next          = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (top)
                begin
                    step.first = end_item;
                    if (end_of_packet)
                    begin
                        step.count             = 2'd2;
                        step.second            = err_item;
                        step.second.error_code = ERR_TRUNC_TS;
                        step.second.run_last   = 1'b1;
                        phase_next             = PH_HEADER;
                    end
                    else
                    begin
                        step.count          = 2'd1;
                        step.first.run_last = 1'b1;
                        stamp_low_next      = packet_byte[6:0];
                        phase_next          = PH_MESSAGE;
                    end
                end
                else
                begin
                    step.first = msg_item;
                    if (end_of_packet)
                    begin
                        step.count           = 2'd2;
                        step.second          = end_item;
                        step.second.run_last = 1'b1;
                        phase_next           = PH_HEADER;
                    end
                    else
                    begin
                        step.count          = 2'd1;
                        step.first.run_last = 1'b1;
                    end
                end
            end
            default:
                phase_next = end_of_packet ? PH_HEADER : PH_DISCARD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            stamp_high_reg <= '0;
            stamp_low_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            stamp_high_reg <= stamp_high_next;
            stamp_low_reg  <= stamp_low_next;
        end
    end

endmodule

// File: rtl/ble_midi_packet_deframer.sv
// A word's results are written into the result queue at the edge that accepts it.
// Throughput: one input word per cycle while in_ready is high; a word that
// causes two results fills two entries of the four-entry result queue.
// Input is ready while the queue has room for two results.
// Reset: asynchronous, active low; clears parse state, registers and queue.
module ble_midi_packet_deframer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [blemd_pkg::AddrW-1:0] paddr,
    input  logic [blemd_pkg::DataW-1:0] pwdata,
    output logic [blemd_pkg::DataW-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  packet_byte,
    input  logic                        end_of_packet,
    input  logic [15:0]                 packet_handle,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  item_kind,
    output logic [7:0]                  message_byte,
    output logic [12:0]                 stamp,
    output logic                        segment_first,
    output logic [1:0]                  error_code,
    output logic                        run_last
);
    import blemd_pkg::*;

    logic [15:0]         accepted_handle_reg;
    logic                receive_enable_reg;
    logic                cfg_write;
    reg_index_t          cfg_index;
    logic                in_accept;
    logic                out_pop;
    step_t               step;
    result_t             fifo_mem [FifoDepth];
    result_t             head;
    logic [FifoPtrW-1:0] wr_ptr_reg;
    logic [FifoPtrW-1:0] rd_ptr_reg;
    logic [FifoCntW-1:0] count_reg;
    logic [FifoCntW-1:0] push_count;
    logic [FifoPtrW-1:0] wr_ptr_second;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_index)
            REG_ACCEPTED_HANDLE: prdata = {{(DataW-16){1'b0}}, accepted_handle_reg};
            REG_RECEIVE_ENABLE:  prdata = {{(DataW-1){1'b0}}, receive_enable_reg};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_handle_reg <= '0;
            receive_enable_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ACCEPTED_HANDLE: accepted_handle_reg <= pwdata[15:0];
                REG_RECEIVE_ENABLE:  receive_enable_reg  <= pwdata[0];
                default:             ;
            endcase
        end
    end

    assign in_ready  = count_reg <= FifoCntW'(FifoDepth - 2);
    assign in_accept = in_valid && in_ready;

    blemd_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (in_accept),
        .packet_byte     (packet_byte),
        .end_of_packet   (end_of_packet),
        .packet_handle   (packet_handle),
        .accepted_handle (accepted_handle_reg),
        .receive_enable  (receive_enable_reg),
        .step            (step)
    );

    assign head          = fifo_mem[rd_ptr_reg];
    assign out_valid     = count_reg != '0;
    assign out_pop       = out_valid && out_ready;
    assign push_count    = in_accept ? FifoCntW'(step.count) : '0;
    assign wr_ptr_second = wr_ptr_reg + FifoPtrW'(1);

    assign item_kind     = head.item_kind;
    assign message_byte  = head.message_byte;
    assign stamp         = head.stamp;
    assign segment_first = head.segment_first;
    assign error_code    = head.error_code;
    assign run_last      = head.run_last;

    always_ff @(posedge clk)
    begin
        if (push_count != '0)
            fifo_mem[wr_ptr_reg] <= step.first;
        if (push_count == FifoCntW'(2))
            fifo_mem[wr_ptr_second] <= step.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FifoPtrW'(push_count);
            if (out_pop)
                rd_ptr_reg <= rd_ptr_reg + FifoPtrW'(1);
            count_reg <= count_reg + push_count - FifoCntW'(out_pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FifoCntW'(FifoDepth))
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step.count == 2'd2) |-> (step.second.run_last && !step.first.run_last))
        else $error("run_last misplaced on a two-result word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && step.count != 2'd0) |=> out_valid)
        else $error("result not presented after producing word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step.count == 2'd1) |-> step.first.run_last)
        else $error("single result lacks run_last");

endmodule
